// File: rtl/eips_pkg.sv
// Shared types and constants for the encoder incremental PID speed block.
// Used by the front, queue, back and top-level modules; depends on nothing else.
package eips_pkg;

    localparam int FRAC_BITS   = 8;

    localparam int GAIN_W      = 16;
    localparam int INTERVAL_W  = 20;
    localparam int SCALE_W     = 16;
    localparam int TIME_W      = 32;
    localparam int POS_W       = 32;
    localparam int TARGET_W    = 16;
    localparam int SPEED_W     = 32;
    localparam int DUTY_W      = 8;
    localparam int DIR_W       = 2;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 20;

    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 20'd1000;
    localparam logic [SCALE_W-1:0]    SCALE_RESET    = 16'd256;

    // Drive is held in fixed point; 250 needs eight integer bits plus sign.
    localparam int DRIVE_LIMIT = 250;
    localparam int DRIVE_W     = FRAC_BITS + 9;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    localparam logic [CFG_INDEX_W-1:0] REG_PROP_GAIN     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_INTEGRAL_GAIN = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DERIV_GAIN    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_INTERVAL      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SPEED_SCALE   = 3'd4;

    localparam logic [DIR_W-1:0] DIR_FWD   = 2'd0;
    localparam logic [DIR_W-1:0] DIR_REV   = 2'd1;
    localparam logic [DIR_W-1:0] DIR_BRAKE = 2'd2;

    typedef struct packed {
        logic [GAIN_W-1:0]     prop_gain;
        logic [GAIN_W-1:0]     integral_gain;
        logic [GAIN_W-1:0]     deriv_gain;
        logic [INTERVAL_W-1:0] update_interval_us;
        logic [SCALE_W-1:0]    speed_scale;
    } cfg_t;

    // One classified encoder event on its way from the front to the back.
    typedef struct packed {
        logic [POS_W-1:0]           position;
        logic                       updated;
        logic [POS_W-1:0]           delta;
        logic [TIME_W-1:0]          elapsed;
        logic signed [TARGET_W-1:0] target;
    } entry_t;

endpackage

// File: rtl/encoder_incremental_pid_speed.sv
// Incremental PID motor speed controller driven by quadrature encoder events.
// An event without a control update goes from idle straight to output; one that runs
// an update also passes the scale, multiply and PID states and the one-bit-per-cycle
// divider that forms interval*scale*delta/elapsed. The front accepts one event per cycle
// into a four-entry queue unless it is full, so short bursts are absorbed while the back
// works. Configuration writes are always taken (cfg_ready is tied high).
module encoder_incremental_pid_speed (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     item_valid,
    output logic                                     item_stall,
    input  logic                                     phase_a,
    input  logic                                     phase_b,
    input  logic [eips_pkg::TIME_W-1:0]              time_us,
    input  logic signed [eips_pkg::TARGET_W-1:0]     target_speed,
    output logic                                     result_valid,
    input  logic                                     result_stall,
    output logic [eips_pkg::POS_W-1:0]               position_count,
    output logic                                     updated,
    output logic signed [eips_pkg::SPEED_W-1:0]      measured_speed,
    output logic [eips_pkg::DIR_W-1:0]               direction,
    output logic [eips_pkg::DUTY_W-1:0]              duty,
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [eips_pkg::CFG_INDEX_W-1:0]         cfg_index,
    input  logic [eips_pkg::CFG_DATA_W-1:0]          cfg_data
);
    import eips_pkg::*;

    cfg_t   cfg_reg;
    logic   q_push;
    entry_t q_push_entry;
    logic   q_pop;
    logic   q_full;
    logic   q_empty;
    entry_t q_head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prop_gain          <= '0;
            cfg_reg.integral_gain      <= '0;
            cfg_reg.deriv_gain         <= '0;
            cfg_reg.update_interval_us <= INTERVAL_RESET;
            cfg_reg.speed_scale        <= SCALE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_PROP_GAIN:     cfg_reg.prop_gain          <= cfg_data[GAIN_W-1:0];
                REG_INTEGRAL_GAIN: cfg_reg.integral_gain      <= cfg_data[GAIN_W-1:0];
                REG_DERIV_GAIN:    cfg_reg.deriv_gain         <= cfg_data[GAIN_W-1:0];
                REG_INTERVAL:      cfg_reg.update_interval_us <= cfg_data[INTERVAL_W-1:0];
                REG_SPEED_SCALE:   cfg_reg.speed_scale        <= cfg_data[SCALE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    eips_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .phase_a      (phase_a),
        .phase_b      (phase_b),
        .time_us      (time_us),
        .target_speed (target_speed),
        .cfg          (cfg_reg),
        .q_full       (q_full),
        .push         (q_push),
        .push_entry   (q_push_entry)
    );

    eips_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_push_entry),
        .pop        (q_pop),
        .full       (q_full),
        .empty      (q_empty),
        .head       (q_head)
    );

    eips_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .q_empty        (q_empty),
        .q_head         (q_head),
        .q_pop          (q_pop),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .position_count (position_count),
        .updated        (updated),
        .measured_speed (measured_speed),
        .direction      (direction),
        .duty           (duty)
    );

endmodule

// File: rtl/eips_front.sv
// Front end: takes encoder events, keeps the position count and decides
// whether an event triggers a control update. Depends on eips_pkg.
module eips_front (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  item_valid,
    output logic                                  item_stall,
    input  logic                                  phase_a,
    input  logic                                  phase_b,
    input  logic [eips_pkg::TIME_W-1:0]           time_us,
    input  logic signed [eips_pkg::TARGET_W-1:0]  target_speed,
    input  eips_pkg::cfg_t                        cfg,
    input  logic                                  q_full,
    output logic                                  push,
    output eips_pkg::entry_t                      push_entry
);
    import eips_pkg::*;

    logic [POS_W-1:0]  position_reg;
    logic [POS_W-1:0]  pos_at_upd_reg;
    logic [TIME_W-1:0] time_at_upd_reg;
    logic [POS_W-1:0]  position_next;
    logic [TIME_W-1:0] elapsed;
    logic              do_update;

    always_comb
    begin
        if (phase_a != phase_b)
        begin
            position_next = position_reg + POS_W'(1);
        end
        else
        begin
            position_next = position_reg - POS_W'(1);
        end
        // Elapsed time wraps with the timestamp.
        elapsed   = time_us - time_at_upd_reg;
        do_update = elapsed > TIME_W'(cfg.update_interval_us);
    end

    assign item_stall = q_full;
    assign push       = item_valid && !q_full;

    assign push_entry.position = position_next;
    assign push_entry.updated  = do_update;
    assign push_entry.delta    = position_next - pos_at_upd_reg;
    assign push_entry.elapsed  = elapsed;
    assign push_entry.target   = target_speed;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg    <= '0;
            pos_at_upd_reg  <= '0;
            time_at_upd_reg <= '0;
        end
        else if (push)
        begin
            position_reg <= position_next;
            if (do_update)
            begin
                pos_at_upd_reg  <= position_next;
                time_at_upd_reg <= time_us;
            end
        end
    end

endmodule

// File: rtl/eips_queue.sv
// Short FIFO of classified events between the front and the back.
// Depends on eips_pkg for the entry type and depth.
module eips_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  eips_pkg::entry_t  push_entry,
    input  logic              pop,
    output logic              full,
    output logic              empty,
    output eips_pkg::entry_t  head
);
    import eips_pkg::*;

    entry_t             slot_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W:0]    count_reg;
    logic [QPTR_W:0]    count_next;

    assign full  = count_reg == (QPTR_W + 1)'(QDEPTH);
    assign empty = count_reg == '0;
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + (QPTR_W + 1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (QPTR_W + 1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QPTR_W + 1)'(QDEPTH))
        else $error("queue count beyond depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !pop)
        else $error("pop from an empty queue");
`endif

endmodule

// File: rtl/eips_back.sv
// Back end: sequencer that measures speed with a shared multiplier and a
// bit-serial divider, runs the incremental PID step and holds the result beat.
// Depends on eips_pkg.
module eips_back (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  eips_pkg::cfg_t                       cfg,
    input  logic                                 q_empty,
    input  eips_pkg::entry_t                     q_head,
    output logic                                 q_pop,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output logic [eips_pkg::POS_W-1:0]           position_count,
    output logic                                 updated,
    output logic signed [eips_pkg::SPEED_W-1:0]  measured_speed,
    output logic [eips_pkg::DIR_W-1:0]           direction,
    output logic [eips_pkg::DUTY_W-1:0]          duty
);
    import eips_pkg::*;

    localparam int A_W     = INTERVAL_W + SCALE_W;
    localparam int A_LO_W  = A_W / 2;
    localparam int A_HI_W  = A_W - A_LO_W;
    localparam int PROD_W  = A_W + POS_W;
    localparam int CNT_W   = $clog2(SPEED_W);
    localparam int ERRX_W  = SPEED_W + 2;
    localparam int D1_W    = SPEED_W + 1;
    localparam int D2_W    = SPEED_W + 3;
    localparam int PP_W    = GAIN_W + 1 + D2_W;
    localparam int SUM_W   = PP_W + 3;
    localparam int DRV_W   = SUM_W + 1;

    localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = DRIVE_W'(DRIVE_LIMIT << FRAC_BITS);
    localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = -DRIVE_MAX;
    localparam logic signed [SPEED_W-1:0] SPEED_MAX = {1'b0, {(SPEED_W - 1){1'b1}}};
    localparam logic signed [SPEED_W-1:0] SPEED_MIN = {1'b1, {(SPEED_W - 1){1'b0}}};

    typedef enum logic [13:0] {
        ST_IDLE      = 14'b00000000000001,
        ST_SCALE     = 14'b00000000000010,
        ST_MUL_LO    = 14'b00000000000100,
        ST_MUL_HI    = 14'b00000000001000,
        ST_DIV_SETUP = 14'b00000000010000,
        ST_DIV       = 14'b00000000100000,
        ST_SPEED     = 14'b00000001000000,
        ST_ERR       = 14'b00000010000000,
        ST_DIFF      = 14'b00000100000000,
        ST_MUL_P     = 14'b00001000000000,
        ST_MUL_I     = 14'b00010000000000,
        ST_MUL_D     = 14'b00100000000000,
        ST_DRIVE     = 14'b01000000000000,
        ST_OUT       = 14'b10000000000000
    } state_t;

    function automatic logic signed [SPEED_W-1:0] sat_speed(
        input logic signed [ERRX_W-1:0] v
    );
        logic signed [SPEED_W-1:0] r;
        if ((v[ERRX_W-1:SPEED_W-1] == '0) || (v[ERRX_W-1:SPEED_W-1] == '1))
        begin
            r = v[SPEED_W-1:0];
        end
        else if (v[ERRX_W-1])
        begin
            r = SPEED_MIN;
        end
        else
        begin
            r = SPEED_MAX;
        end
        return r;
    endfunction

    // Control state and controller history.
    state_t                     state_reg, state_next;
    logic                       valid_reg, valid_next;
    logic signed [SPEED_W-1:0]  speed_reg, speed_next;
    logic signed [SPEED_W-1:0]  e1_reg, e1_next;
    logic signed [SPEED_W-1:0]  e2_reg, e2_next;
    logic signed [DRIVE_W-1:0]  drive_reg, drive_next;

    // Working registers.
    entry_t                     cur_reg, cur_next;
    logic [A_W-1:0]             a_reg, a_next;
    logic [PROD_W-1:0]          prod_reg, prod_next;
    logic                       ovf_reg, ovf_next;
    logic [POS_W-1:0]           rem_reg, rem_next;
    logic [SPEED_W-1:0]         quo_reg, quo_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic signed [SPEED_W-1:0]  e_reg, e_next;
    logic signed [D1_W-1:0]     d1_reg, d1_next;
    logic signed [D2_W-1:0]     d2_reg, d2_next;
    logic signed [SUM_W-1:0]    sum_reg, sum_next;

    // Result beat.
    logic [POS_W-1:0]           pos_out_reg, pos_out_next;
    logic                       upd_out_reg, upd_out_next;
    logic signed [SPEED_W-1:0]  spd_out_reg, spd_out_next;
    logic [DIR_W-1:0]           dir_out_reg, dir_out_next;
    logic [DUTY_W-1:0]          duty_out_reg, duty_out_next;

    // Datapath helpers.
    logic                       delta_neg;
    logic [POS_W-1:0]           mag;
    logic [A_HI_W-1:0]          sp_opa;
    logic [A_HI_W+POS_W-1:0]    sp_prod;
    logic [POS_W:0]             div_trial;
    logic [POS_W:0]             div_diff;
    logic                       div_ge;
    logic signed [ERRX_W-1:0]   tgt_q;
    logic signed [ERRX_W-1:0]   err_diff;
    logic [GAIN_W-1:0]          pid_gain;
    logic signed [GAIN_W:0]     pid_opa;
    logic signed [D2_W-1:0]     pid_opb;
    logic signed [PP_W-1:0]     pid_prod;
    logic signed [SUM_W-1:0]    sum_shr;
    logic signed [DRV_W-1:0]    drv;
    logic signed [DRIVE_W-1:0]  drive_abs;
    logic                       out_free;

    assign delta_neg = cur_reg.delta[POS_W-1];
    assign mag       = delta_neg ? (POS_W'(0) - cur_reg.delta) : cur_reg.delta;

    // One unsigned multiplier serves both halves of interval*scale*|delta|.
    assign sp_opa  = (state_reg == ST_MUL_HI) ? a_reg[A_W-1:A_LO_W]
                                              : A_HI_W'(a_reg[A_LO_W-1:0]);
    assign sp_prod = (A_HI_W + POS_W)'(sp_opa) * (A_HI_W + POS_W)'(mag);

    // Restoring divider step: one quotient bit per cycle.
    assign div_trial = {rem_reg, quo_reg[SPEED_W-1]};
    assign div_diff  = div_trial - {1'b0, cur_reg.elapsed};
    assign div_ge    = div_trial >= {1'b0, cur_reg.elapsed};

    assign tgt_q    = ERRX_W'(cur_reg.target) <<< FRAC_BITS;
    assign err_diff = ERRX_W'(speed_reg) - tgt_q;

    // One signed multiplier serves the three PID terms in turn.
    always_comb
    begin
        pid_gain = cfg.prop_gain;
        pid_opb  = D2_W'(d1_reg);
        case (state_reg)
            ST_MUL_I:
            begin
                pid_gain = cfg.integral_gain;
                pid_opb  = D2_W'(e_reg);
            end
            ST_MUL_D:
            begin
                pid_gain = cfg.deriv_gain;
                pid_opb  = d2_reg;
            end
            default:
            begin
                pid_gain = cfg.prop_gain;
                pid_opb  = D2_W'(d1_reg);
            end
        endcase
    end

    assign pid_opa  = {1'b0, pid_gain};
    assign pid_prod = PP_W'(pid_opa) * PP_W'(pid_opb);

    // Arithmetic shift floors toward minus infinity.
    assign sum_shr   = sum_reg >>> FRAC_BITS;
    assign drv       = DRV_W'(drive_reg) - DRV_W'(sum_shr);
    assign drive_abs = drive_reg[DRIVE_W-1] ? -drive_reg : drive_reg;
    assign out_free  = !valid_reg || !result_stall;

    always_comb
    begin
        state_next    = state_reg;
        valid_next    = valid_reg;
        speed_next    = speed_reg;
        e1_next       = e1_reg;
        e2_next       = e2_reg;
        drive_next    = drive_reg;
        cur_next      = cur_reg;
        a_next        = a_reg;
        prod_next     = prod_reg;
        ovf_next      = ovf_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        cnt_next      = cnt_reg;
        e_next        = e_reg;
        d1_next       = d1_reg;
        d2_next       = d2_reg;
        sum_next      = sum_reg;
        pos_out_next  = pos_out_reg;
        upd_out_next  = upd_out_reg;
        spd_out_next  = spd_out_reg;
        dir_out_next  = dir_out_reg;
        duty_out_next = duty_out_reg;
        q_pop         = 1'b0;

        if (valid_reg && !result_stall)
        begin
            valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop    = 1'b1;
                    cur_next = q_head;
                    state_next = q_head.updated ? ST_SCALE : ST_OUT;
                end
            end
            ST_SCALE:
            begin
                a_next     = A_W'(cfg.update_interval_us) * A_W'(cfg.speed_scale);
                state_next = ST_MUL_LO;
            end
            ST_MUL_LO:
            begin
                prod_next  = PROD_W'(sp_prod);
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI:
            begin
                prod_next  = prod_reg + {sp_prod, {A_LO_W{1'b0}}};
                state_next = ST_DIV_SETUP;
            end
            ST_DIV_SETUP:
            begin
                // A quotient of 2^32 or more saturates, so only the low word is divided.
                ovf_next   = prod_reg[PROD_W-1:POS_W] >= A_W'(cur_reg.elapsed);
                rem_next   = prod_reg[2*POS_W-1:POS_W];
                quo_next   = prod_reg[SPEED_W-1:0];
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                rem_next = div_ge ? div_diff[POS_W-1:0] : div_trial[POS_W-1:0];
                quo_next = {quo_reg[SPEED_W-2:0], div_ge};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(SPEED_W - 1))
                begin
                    state_next = ST_SPEED;
                end
            end
            ST_SPEED:
            begin
                if (delta_neg)
                begin
                    if (ovf_reg || (quo_reg[SPEED_W-1] && (quo_reg[SPEED_W-2:0] != '0)))
                    begin
                        speed_next = SPEED_MIN;
                    end
                    else
                    begin
                        speed_next = SPEED_W'(0) - quo_reg;
                    end
                end
                else
                begin
                    if (ovf_reg || quo_reg[SPEED_W-1])
                    begin
                        speed_next = SPEED_MAX;
                    end
                    else
                    begin
                        speed_next = quo_reg;
                    end
                end
                state_next = ST_ERR;
            end
            ST_ERR:
            begin
                e_next     = sat_speed(err_diff);
                state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                d1_next    = D1_W'(e_reg) - D1_W'(e1_reg);
                d2_next    = D2_W'(e_reg) - (D2_W'(e1_reg) <<< 1) + D2_W'(e2_reg);
                state_next = ST_MUL_P;
            end
            ST_MUL_P:
            begin
                sum_next   = SUM_W'(pid_prod);
                state_next = ST_MUL_I;
            end
            ST_MUL_I:
            begin
                sum_next   = sum_reg + SUM_W'(pid_prod);
                state_next = ST_MUL_D;
            end
            ST_MUL_D:
            begin
                sum_next   = sum_reg + SUM_W'(pid_prod);
                state_next = ST_DRIVE;
            end
            ST_DRIVE:
            begin
                if (drv > DRV_W'(DRIVE_MAX))
                begin
                    drive_next = DRIVE_MAX;
                end
                else if (drv < DRV_W'(DRIVE_MIN))
                begin
                    drive_next = DRIVE_MIN;
                end
                else
                begin
                    drive_next = drv[DRIVE_W-1:0];
                end
                e2_next    = e1_reg;
                e1_next    = e_reg;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    valid_next   = 1'b1;
                    pos_out_next = cur_reg.position;
                    upd_out_next = cur_reg.updated;
                    spd_out_next = speed_reg;
                    if (drive_reg == '0)
                    begin
                        dir_out_next  = DIR_BRAKE;
                        duty_out_next = '0;
                    end
                    else
                    begin
                        dir_out_next  = drive_reg[DRIVE_W-1] ? DIR_REV : DIR_FWD;
                        duty_out_next = drive_abs[FRAC_BITS+DUTY_W-1:FRAC_BITS];
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
            speed_reg <= '0;
            e1_reg    <= '0;
            e2_reg    <= '0;
            drive_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            speed_reg <= speed_next;
            e1_reg    <= e1_next;
            e2_reg    <= e2_next;
            drive_reg <= drive_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        a_reg        <= a_next;
        prod_reg     <= prod_next;
        ovf_reg      <= ovf_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        cnt_reg      <= cnt_next;
        e_reg        <= e_next;
        d1_reg       <= d1_next;
        d2_reg       <= d2_next;
        sum_reg      <= sum_next;
        pos_out_reg  <= pos_out_next;
        upd_out_reg  <= upd_out_next;
        spd_out_reg  <= spd_out_next;
        dir_out_reg  <= dir_out_next;
        duty_out_reg <= duty_out_next;
    end

    assign result_valid   = valid_reg;
    assign position_count = pos_out_reg;
    assign updated        = upd_out_reg;
    assign measured_speed = spd_out_reg;
    assign direction      = dir_out_reg;
    assign duty           = duty_out_reg;

`ifndef NO_ASSERTIONS
    a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
        (drive_reg <= DRIVE_MAX) && (drive_reg >= DRIVE_MIN))
        else $error("drive accumulator outside its clamp");

    a_div_remainder: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) && !ovf_reg |-> (rem_reg < cur_reg.elapsed))
        else $error("divider remainder not below divisor");

    a_brake_duty: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (direction == DIR_BRAKE) |-> (duty == '0))
        else $error("nonzero duty while braking");
`endif

endmodule
